// ----- rtl/core/mdf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the multibyte delta filter: field widths, configuration
// register indexes and the control structs passed between its modules.
// No dependencies.
package mdf_pkg;

    localparam int BYTE_W      = 8;
    localparam int ELEM_SIZE_W = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [ELEM_SIZE_W-1:0] ELEM_SIZE_RESET = 9'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_SIZE = 1'b0,
        CFG_MODE_UNDIFF  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic first_row;
        logic first_byte;
    } t_pos_ctl;

    typedef struct packed {
        logic first_row;
        logic first_byte;
        logic mode_undiff;
    } t_slot_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/mdf_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the multibyte delta filter: valid, ready, one raw byte and start_of_table.
// Depends on mdf_pkg.
interface mdf_in_if
    import mdf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              start_of_table;

    modport source (output valid, output byte_in, output start_of_table, input ready);
    modport sink   (input valid, input byte_in, input start_of_table, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mdf_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output channel of the multibyte delta filter: valid, ready and one result byte.
// Depends on mdf_pkg.
interface mdf_out_if
    import mdf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;

    modport source (output valid, output byte_out, input ready);
    modport sink   (input valid, input byte_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mdf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Row buffer of the delta filter: one write port, one read port, registered read data.
// Depends on mdf_pkg.
module mdf_ram
    import mdf_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/mdf_pos.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Element position tracker: byte position within the element and first-row flag.
// Depends on mdf_pkg.
module mdf_pos
    import mdf_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 256,
    parameter int PW            = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic                   i_sot,
    input  wire logic [ELEM_SIZE_W-1:0] i_elem_size,
    output logic      [PW-1:0]          o_pos,
    output t_pos_ctl                    o_ctl
);

    localparam int NW = ($clog2(MAX_ROW_BYTES + 1) > ELEM_SIZE_W) ?
                        $clog2(MAX_ROW_BYTES + 1) : ELEM_SIZE_W;

    logic [PW-1:0] r_pos, n_pos;
    logic          r_first, n_first;
    logic [NW-1:0] size_ext, row_n, pos_ext, pos_nxt;
    logic [PW-1:0] pos_cur;
    logic          first_cur;

    always_comb begin
        size_ext = NW'(i_elem_size);
        if (size_ext == '0) begin
            row_n = NW'(1);
        end else if (size_ext > NW'(MAX_ROW_BYTES)) begin
            row_n = NW'(MAX_ROW_BYTES);
        end else begin
            row_n = size_ext;
        end

        pos_ext = NW'(r_pos);
        if (i_sot) begin
            pos_cur   = '0;
            first_cur = 1'b1;
        end else if (pos_ext >= row_n) begin
            pos_cur   = '0;
            first_cur = 1'b0;
        end else begin
            pos_cur   = r_pos;
            first_cur = r_first;
        end

        pos_nxt = NW'(pos_cur) + NW'(1);
        if (pos_nxt >= row_n) begin
            n_pos   = '0;
            n_first = 1'b0;
        end else begin
            n_pos   = pos_nxt[PW-1:0];
            n_first = first_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_first <= n_first;
        end
    end

    assign o_pos            = pos_cur;
    assign o_ctl.first_row  = first_cur;
    assign o_ctl.first_byte = (pos_cur == '0);

endmodule

`default_nettype wire

// ----- rtl/core/mdf_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Byte arithmetic of the delta filter: subtract with borrow or add with carry,
// and the carry register between bytes of an element. Depends on mdf_pkg.
module mdf_calc
    import mdf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_prev,
    input  wire t_slot_ctl         i_ctl,
    output logic      [BYTE_W-1:0] o_result,
    output logic      [BYTE_W-1:0] o_wdata
);

    logic          r_carry, n_carry;
    logic          carry_in;
    logic [BYTE_W:0] sum, sub;

    always_comb begin
        carry_in = i_ctl.first_byte ? 1'b0 : r_carry;
        sum      = {1'b0, i_byte} + {1'b0, i_prev} + {{BYTE_W{1'b0}}, carry_in};
        sub      = {1'b0, i_prev} + {{BYTE_W{1'b0}}, carry_in};
        if (i_ctl.first_row) begin
            o_result = i_byte;
            o_wdata  = i_byte;
            n_carry  = 1'b0;
        end else if (i_ctl.mode_undiff) begin
            o_result = sum[BYTE_W-1:0];
            o_wdata  = sum[BYTE_W-1:0];
            n_carry  = sum[BYTE_W];
        end else begin
            o_result = i_byte - sub[BYTE_W-1:0];
            o_wdata  = i_byte;
            n_carry  = ({1'b0, i_byte} < sub);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 1'b0;
        end else if (i_advance) begin
            r_carry <= n_carry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/multibyte_delta_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Multibyte delta filter, top level.
// Takes one byte item per cycle on i_in (valid/ready) and gives one filtered
// byte item on o_out for each. With mode_undiff clear, every element after the
// first of a table has the previous element subtracted with a borrow running
// from its lowest byte; with it set, the previous rebuilt element is added back
// with a carry. start_of_table begins a new table whose first element passes.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce:
// index CFG_ELEMENT_SIZE sets bytes per element, CFG_MODE_UNDIFF the direction.
// An accepted item is registered in the arithmetic stage and then in the output
// register before it shows on o_out. Throughput is one item per cycle while
// the receiver does not stall: the row buffer is read on accept and written back
// in the arithmetic stage, with a bypass when both touch the same byte.
// Reset clears the pipeline, sets element size 4 and diff mode, and treats the
// following stream as a new table. When the receiver stalls, the result stays
// in the output register, one more item waits in the arithmetic stage, and
// i_in.ready falls until the output moves.
module multibyte_delta_filter_unit
    import mdf_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mdf_in_if.sink                     i_in,
    mdf_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_ROW_BYTES);

    logic [ELEM_SIZE_W-1:0] r_elem_size;
    logic                   r_mode_undiff;

    logic                   accept, advance, s1_go;
    logic [PW-1:0]          pos_cur;
    t_pos_ctl               pos_ctl;
    logic [BYTE_W-1:0]      ram_rdata, prev, result, wdata;

    logic                   r_s1_valid;
    logic [BYTE_W-1:0]      r_s1_byte;
    logic [PW-1:0]          r_s1_pos;
    t_slot_ctl              r_s1_ctl;
    logic                   r_s1_byp;
    logic [BYTE_W-1:0]      r_s1_byp_data;

    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;

    assign advance    = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_size   <= ELEM_SIZE_RESET;
            r_mode_undiff <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ELEMENT_SIZE: r_elem_size   <= i_cfg_data[ELEM_SIZE_W-1:0];
                CFG_MODE_UNDIFF:  r_mode_undiff <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mdf_pos #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .PW            (PW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sot       (i_in.start_of_table),
        .i_elem_size (r_elem_size),
        .o_pos       (pos_cur),
        .o_ctl       (pos_ctl)
    );

    mdf_ram #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_pos),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (pos_cur),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte            <= i_in.byte_in;
            r_s1_pos             <= pos_cur;
            r_s1_ctl.first_row   <= pos_ctl.first_row;
            r_s1_ctl.first_byte  <= pos_ctl.first_byte;
            r_s1_ctl.mode_undiff <= r_mode_undiff;
            r_s1_byp             <= s1_go && (r_s1_pos == pos_cur);
            r_s1_byp_data        <= wdata;
        end
    end

    assign prev = r_s1_byp ? r_s1_byp_data : ram_rdata;

    mdf_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_go),
        .i_byte    (r_s1_byte),
        .i_prev    (prev),
        .i_ctl     (r_s1_ctl),
        .o_result  (result),
        .o_wdata   (wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_byte <= result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.byte_out = r_out_byte;

endmodule

`default_nettype wire

// ----- rtl/core/mdf_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the multibyte delta filter, bound to the top level.
// Depends on mdf_pkg and multibyte_delta_filter_unit.
module mdf_chk
    import mdf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [BYTE_W-1:0] i_in_byte,
    input wire logic              i_in_sot,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [BYTE_W-1:0] i_out_byte
);

    logic       in_acc, out_acc;
    logic [1:0] r_cnt, n_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;
    assign n_cnt   = r_cnt + {1'b0, in_acc} - {1'b0, out_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("Output valid right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("Stalled output item changed.");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("More than two items in flight.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input not ready while output register is empty.");

    a_first_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_sot && r_cnt == 2'd0
        |=> ##1 i_out_valid && i_out_byte == $past(i_in_byte, 2))
        else $error("First byte of a table did not pass unchanged.");

endmodule

bind multibyte_delta_filter_unit mdf_chk u_mdf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_byte   (i_in.byte_in),
    .i_in_sot    (i_in.start_of_table),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.byte_out)
);

`default_nettype wire
